FILE: design/pwt_pkg.sv
// shared types and constants for the perceptron weight trainer
// no dependencies; used by pwt_cell and perceptron_weight_trainer_core
package pwt_pkg;

    // sample shape
    localparam int FEATURES  = 4;
    localparam int CELLS     = FEATURES + 1;
    localparam int CNT_W     = (CELLS > 1) ? $clog2(CELLS) : 1;

    // arithmetic widths
    localparam int FEAT_W    = 8;
    localparam int WGT_W     = 32;
    localparam int PROD_W    = WGT_W + FEAT_W;
    localparam int SUM_W     = PROD_W + $clog2(CELLS);
    localparam int GAIN_W    = 8;
    localparam int GT_W      = GAIN_W + FEAT_W + 1;
    localparam int DELTA_W   = GT_W + FEAT_W;
    localparam int OSUM_W    = 48;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_INPUT    = 2'd1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_UPD
    } t_state;

    // per-cycle control shared by every cell
    typedef struct packed {
        logic prod_en;
        logic upd_en;
    } t_cell_ctl;

endpackage

FILE: design/pwt_cell.sv
// one cell of the trainer chain: holds one weight, forms its product term,
// adds it to the neighbor's partial sum and applies the saturating update
// depends on pwt_pkg
module pwt_cell
    import pwt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [FEAT_W-1:0]  i_feat,
    input  logic signed [GT_W-1:0]    i_gt,
    input  logic signed [SUM_W-1:0]   i_psum,
    output logic signed [SUM_W-1:0]   o_psum,
    output logic signed [WGT_W-1:0]   o_weight_next
);

    logic signed [WGT_W-1:0]   r_weight;
    logic signed [WGT_W-1:0]   n_weight;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [DELTA_W-1:0] r_delta;
    logic signed [DELTA_W-1:0] n_delta;
    logic signed [SUM_W-1:0]   r_psum;
    logic signed [SUM_W-1:0]   n_psum;
    logic signed [WGT_W:0]     w_wsum;

    // product of weight and feature, and the update step gain*target*feature
    assign n_prod  = PROD_W'(r_weight) * PROD_W'(i_feat);
    assign n_delta = DELTA_W'(i_gt) * DELTA_W'(i_feat);

    // partial sum handed along the chain every cycle
    assign n_psum = i_psum + SUM_W'(r_prod);
    assign o_psum = r_psum;

    // saturating weight update
    always_comb begin
        w_wsum = (WGT_W+1)'(r_weight) + (WGT_W+1)'(r_delta);
        if (w_wsum[WGT_W] != w_wsum[WGT_W-1]) begin
            n_weight = w_wsum[WGT_W] ? {1'b1, {(WGT_W-1){1'b0}}}
                                     : {1'b0, {(WGT_W-1){1'b1}}};
        end else begin
            n_weight = w_wsum[WGT_W-1:0];
        end
    end

    // weight value the cell will hold after this step
    assign o_weight_next = i_ctl.upd_en ? n_weight : r_weight;

    // weight state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
        end else if (i_ctl.upd_en) begin
            r_weight <= n_weight;
        end
    end

    // product terms and partial sum
    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_prod  <= n_prod;
            r_delta <= n_delta;
        end
        r_psum <= n_psum;
    end

endmodule

FILE: design/perceptron_weight_trainer_core.sv
// top level of the perceptron weight trainer: sequencer, config registers,
// epoch tracking, output register and the chain of weight cells
// depends on pwt_pkg and pwt_cell
//
// channel   direction  handshake                  payload
// sample    in         i_in_valid / o_in_stall     features a..d, target, epoch_end
// result    out        o_out_valid / i_out_stall   sum, flags, five weights
// config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
// a sample passes from capture through a multiply state, a sum state that ripples
// the sum down the chain of CELLS cells, and an update state that registers the result.
// one sample in flight; the next is accepted the cycle after the result is
// registered; a stalled result holds the next sample in the update state.
// synchronous active-low reset zeroes the weights and the epoch flag and sets
// gain and bias input to 1.
module perceptron_weight_trainer_core
    import pwt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DAT_W-1:0]      i_cfg_data,
    // sample channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [FEAT_W-1:0]  i_feature_a,
    input  logic signed [FEAT_W-1:0]  i_feature_b,
    input  logic signed [FEAT_W-1:0]  i_feature_c,
    input  logic signed [FEAT_W-1:0]  i_feature_d,
    input  logic signed [FEAT_W-1:0]  i_target,
    input  logic                      i_epoch_end,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [OSUM_W-1:0]  o_weighted_sum,
    output logic                      o_misclassified,
    output logic                      o_epoch_clean,
    output logic signed [WGT_W-1:0]   o_bias_weight,
    output logic signed [WGT_W-1:0]   o_weight_a,
    output logic signed [WGT_W-1:0]   o_weight_b,
    output logic signed [WGT_W-1:0]   o_weight_c,
    output logic signed [WGT_W-1:0]   o_weight_d
);

    t_state                     r_state;
    t_state                     n_state;
    logic [CNT_W-1:0]           r_cnt;
    logic [GAIN_W-1:0]          r_gain;
    logic signed [FEAT_W-1:0]   r_bias_in;
    logic signed [FEAT_W-1:0]   r_feat [FEATURES];
    logic signed [FEAT_W-1:0]   w_in_feat [FEATURES];
    logic signed [FEAT_W-1:0]   w_cell_feat [CELLS];
    logic signed [FEAT_W-1:0]   r_target;
    logic                       r_last;
    logic signed [GT_W-1:0]     r_gt;
    logic signed [GT_W-1:0]     n_gt;
    logic                       r_err_seen;
    logic                       r_out_valid;
    logic signed [OSUM_W-1:0]   r_out_sum;
    logic                       r_out_mis;
    logic                       r_out_clean;
    logic signed [WGT_W-1:0]    r_out_w [CELLS];
    logic signed [SUM_W-1:0]    w_psum [CELLS];
    logic signed [WGT_W-1:0]    w_wnext [CELLS];
    logic signed [SUM_W-1:0]    w_sum;
    logic                       w_accept;
    logic                       w_take;
    logic                       w_upd_go;
    logic                       w_mis;
    logic                       w_clean;
    t_cell_ctl                  w_ctl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= GAIN_W'(1);
            r_bias_in <= FEAT_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEARNING_GAIN: r_gain    <= i_cfg_data;
                CFG_BIAS_INPUT:    r_bias_in <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // handshakes
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_take   = r_out_valid && !i_out_stall;
    assign w_upd_go = (r_state == ST_UPD) && (!r_out_valid || !i_out_stall);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_MUL;
            ST_MUL:  n_state = ST_SUM;
            ST_SUM:  if (r_cnt == CNT_W'(CELLS - 1)) n_state = ST_UPD;
            ST_UPD:  if (w_upd_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall    = (r_state != ST_IDLE);
        w_ctl.prod_en = (r_state == ST_MUL);
        w_ctl.upd_en  = w_upd_go && w_mis;
    end

    // state and ripple counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SUM) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // sample capture, gain times target formed on the way in
    assign w_in_feat[0] = i_feature_a;
    assign w_in_feat[1] = i_feature_b;
    assign w_in_feat[2] = i_feature_c;
    assign w_in_feat[3] = i_feature_d;
    assign n_gt = GT_W'($signed({1'b0, r_gain})) * GT_W'(i_target);

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int k = 0; k < FEATURES; k++) begin
                r_feat[k] <= w_in_feat[k];
            end
            r_target <= i_target;
            r_last   <= i_epoch_end;
            r_gt     <= n_gt;
        end
    end

    // cell chain, cell 0 carries the bias weight
    assign w_cell_feat[0] = r_bias_in;

    genvar g;
    generate
        for (g = 0; g < CELLS; g++) begin : g_cell
            if (g > 0) begin : g_feat
                assign w_cell_feat[g] = r_feat[g-1];
            end
            pwt_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_feat        (w_cell_feat[g]),
                .i_gt          (r_gt),
                .i_psum        ((g == 0) ? SUM_W'(0) : w_psum[(g == 0) ? 0 : g-1]),
                .o_psum        (w_psum[g]),
                .o_weight_next (w_wnext[g])
            );
        end
    endgenerate

    // decision on the finished sum
    assign w_sum   = w_psum[CELLS-1];
    assign w_mis   = r_target[FEAT_W-1] != w_sum[SUM_W-1];
    assign w_clean = r_last && !(r_err_seen || w_mis);

    // epoch error tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_seen <= 1'b0;
        end else if (w_upd_go) begin
            r_err_seen <= r_last ? 1'b0 : (r_err_seen || w_mis);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_upd_go) begin
            r_out_valid <= 1'b1;
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd_go) begin
            r_out_sum   <= OSUM_W'(w_sum);
            r_out_mis   <= w_mis;
            r_out_clean <= w_clean;
            for (int k = 0; k < CELLS; k++) begin
                r_out_w[k] <= w_wnext[k];
            end
        end
    end

    // result word
    assign o_out_valid     = r_out_valid;
    assign o_weighted_sum  = r_out_sum;
    assign o_misclassified = r_out_mis;
    assign o_epoch_clean   = r_out_clean;
    assign o_bias_weight   = r_out_w[0];
    assign o_weight_a      = r_out_w[1];
    assign o_weight_b      = r_out_w[2];
    assign o_weight_c      = r_out_w[3];
    assign o_weight_d      = r_out_w[4];

endmodule

FILE: sim/perceptron_weight_trainer_core_test.sv
// self-checking testbench for perceptron_weight_trainer_core: directed and random sample words,
// register writes between phases, every result word checked against a scoreboard prediction
// depends on pwt_pkg and the core rtl
module perceptron_weight_trainer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pwt_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 10;
    localparam int PHASES         = 8;
    localparam int PHASE_WORDS    = 250;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_MAX     = 10;

    localparam longint WGT_MAX = 2147483647;
    localparam longint WGT_MIN = -WGT_MAX - 1;

    // register indexes past the end of the map, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [FEATURES-1:0][FEAT_W-1:0] feat;
        logic [FEAT_W-1:0]               tgt;
        logic                            last;
    } t_sample;

    // cell 0 is the bias weight, cells 1..4 the feature weights
    typedef struct packed {
        logic [OSUM_W-1:0]            sum;
        logic                         mis;
        logic                         clean;
        logic [CELLS-1:0][WGT_W-1:0]  wgt;
    } t_step;

    // training model: weights, epoch flag, registers and the steps still owed by the core
    class t_trainer_scoreboard;
        logic [WGT_W-1:0]  wgt [CELLS];
        bit                epoch_err;
        logic [GAIN_W-1:0] gain;
        logic [FEAT_W-1:0] bias_in;
        t_step             pending_steps [$];
        int                mismatches;

        function void clear();
            foreach (wgt[i]) wgt[i] = '0;
            epoch_err = 1'b0;
            gain = 8'd1;
            bias_in = 8'd1;
            pending_steps.delete();
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_LEARNING_GAIN: gain = data;
                CFG_BIAS_INPUT:    bias_in = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_steps.size();
        endfunction

        // one training step for an accepted sample word
        function void take_sample(t_sample s);
            longint x [CELLS];
            longint acc;
            longint tgt;
            longint nxt;
            bit     mis;
            t_step  r;
            x[0] = $signed(bias_in);
            for (int i = 0; i < FEATURES; i++) x[i+1] = $signed(s.feat[i]);
            tgt = $signed(s.tgt);

            // dot product with the weights before the update
            acc = 0;
            for (int i = 0; i < CELLS; i++) acc += $signed(wgt[i]) * x[i];

            // zero sum and zero target both count as non-negative
            mis = (tgt < 0) != (acc < 0);
            if (mis) begin
                for (int i = 0; i < CELLS; i++) begin
                    nxt = $signed(wgt[i]) + longint'(gain) * tgt * x[i];
                    if (nxt > WGT_MAX) nxt = WGT_MAX;
                    else if (nxt < WGT_MIN) nxt = WGT_MIN;
                    wgt[i] = nxt[WGT_W-1:0];
                end
            end

            r.sum = acc[OSUM_W-1:0];
            r.mis = mis;
            // clean flag only at the epoch mark, error history cleared there
            if (s.last) begin
                r.clean = !(epoch_err || mis);
                epoch_err = 1'b0;
            end else begin
                r.clean = 1'b0;
                if (mis) epoch_err = 1'b1;
            end
            for (int i = 0; i < CELLS; i++) r.wgt[i] = wgt[i];
            pending_steps.push_back(r);
        endfunction

        function void compare(string field, longint want_v, longint got_v);
            if (want_v != got_v) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("mismatch on %s: expected %0d, got %0d", field, want_v, got_v);
            end
        endfunction

        function void check_step(t_step got);
            t_step want;
            if (pending_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result word with no step pending, sum %0d", $signed(got.sum));
                return;
            end
            want = pending_steps.pop_front();
            compare("weighted_sum", $signed(want.sum), $signed(got.sum));
            compare("misclassified", want.mis, got.mis);
            compare("epoch_clean", want.clean, got.clean);
            for (int i = 0; i < CELLS; i++)
                compare($sformatf("weight cell %0d", i), $signed(want.wgt[i]),
                        $signed(got.wgt[i]));
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [CFG_DAT_W-1:0]     i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic signed [FEAT_W-1:0] i_feature_a;
    logic signed [FEAT_W-1:0] i_feature_b;
    logic signed [FEAT_W-1:0] i_feature_c;
    logic signed [FEAT_W-1:0] i_feature_d;
    logic signed [FEAT_W-1:0] i_target;
    logic                     i_epoch_end;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [OSUM_W-1:0] o_weighted_sum;
    logic                     o_misclassified;
    logic                     o_epoch_clean;
    logic signed [WGT_W-1:0]  o_bias_weight;
    logic signed [WGT_W-1:0]  o_weight_a;
    logic signed [WGT_W-1:0]  o_weight_b;
    logic signed [WGT_W-1:0]  o_weight_c;
    logic signed [WGT_W-1:0]  o_weight_d;

    t_trainer_scoreboard sb;
    bit                  quiet;
    int                  stall_left;
    int                  idle_count;
    int                  teacher [CELLS];
    t_sample             train_set [$];

    perceptron_weight_trainer_core dut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // idle length: mostly none, some short, a few long; none in quiet phases
    function automatic int idle_cycles();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [FEAT_W-1:0] rand_feat();
        case ($urandom_range(0, 9))
            0: return 8'h80;
            1: return 8'h7F;
            default: return FEAT_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_sample make_sample(int a, int b, int c, int d, int t, bit last);
        t_sample s;
        s.feat[0] = a[FEAT_W-1:0];
        s.feat[1] = b[FEAT_W-1:0];
        s.feat[2] = c[FEAT_W-1:0];
        s.feat[3] = d[FEAT_W-1:0];
        s.tgt = t[FEAT_W-1:0];
        s.last = last;
        return s;
    endfunction

    // sample labelled by the phase's separating vector, so epochs can converge
    function automatic t_sample labelled_sample(int bias);
        t_sample s;
        int      dot;
        int      m;
        dot = teacher[0] * bias;
        for (int i = 0; i < FEATURES; i++) begin
            s.feat[i] = rand_feat();
            dot += teacher[i+1] * $signed(s.feat[i]);
        end
        if (dot >= 0) begin
            m = $urandom_range(0, 127);
        end else begin
            m = -int'($urandom_range(1, 128));
        end
        s.tgt = m[FEAT_W-1:0];
        s.last = 1'b0;
        return s;
    endfunction

    function automatic t_sample noise_sample();
        t_sample s;
        for (int i = 0; i < FEATURES; i++) s.feat[i] = rand_feat();
        s.tgt = rand_feat();
        s.last = ($urandom_range(0, 3) == 0);
        return s;
    endfunction

    // present one sample word and hold it until taken
    task automatic send_sample(t_sample s);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_feature_a <= s.feat[0];
        i_feature_b <= s.feat[1];
        i_feature_c <= s.feat[2];
        i_feature_d <= s.feat[3];
        i_target    <= s.tgt;
        i_epoch_end <= s.last;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_sample(s);
    endtask

    // wait until every predicted step has come back
    task automatic drain();
        do @(negedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // new register settings, only once the core has gone idle
    task automatic configure(int gain, int bias, bit spare);
        i_in_valid <= 1'b0;
        drain();
        cfg_write(CFG_LEARNING_GAIN, gain[CFG_DAT_W-1:0]);
        if (spare) begin
            cfg_write(CFG_SPARE_A, CFG_DAT_W'($urandom_range(0, 255)));
            cfg_write(CFG_SPARE_B, CFG_DAT_W'($urandom_range(0, 255)));
        end
        cfg_write(CFG_BIAS_INPUT, bias[CFG_DAT_W-1:0]);
        i_cfg_we <= 1'b0;
    endtask

    // result side: check taken words, stall at random
    always @(posedge i_clk) begin
        t_step got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.sum   = o_weighted_sum;
            got.mis   = o_misclassified;
            got.clean = o_epoch_clean;
            got.wgt[0] = o_bias_weight;
            got.wgt[1] = o_weight_a;
            got.wgt[2] = o_weight_b;
            got.wgt[3] = o_weight_c;
            got.wgt[4] = o_weight_d;
            sb.check_step(got);
        end
        if (stall_left == 0) stall_left = idle_cycles();
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_count = 0;
        end else begin
            idle_count++;
        end
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("perceptron_weight_trainer_core verification failed");
            $finish;
        end
    end

    initial begin
        int      bias;
        int      sent;
        int      n;
        bit      broken;
        t_sample s;

        sb = new;
        sb.clear();
        quiet = 1'b0;
        stall_left = 0;
        idle_count = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_feature_a <= '0;
        i_feature_b <= '0;
        i_feature_c <= '0;
        i_feature_d <= '0;
        i_target    <= '0;
        i_epoch_end <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero sums, zero and negative targets, extremes
        send_sample(make_sample(0, 0, 0, 0, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, -1, 1));
        send_sample(make_sample(127, 127, 127, 127, 127, 0));
        send_sample(make_sample(-128, -128, -128, -128, -128, 0));
        send_sample(make_sample(127, -128, 127, -128, 0, 0));
        send_sample(make_sample(1, 2, 3, 4, -128, 1));

        // gain of zero: errors flagged, weights frozen; spare indexes ignored
        configure(0, 127, 1'b1);
        send_sample(make_sample(127, 0, -128, 5, -128, 0));
        send_sample(make_sample(-7, 99, 0, -128, 127, 0));
        send_sample(make_sample(0, 0, 0, 0, 0, 1));

        // largest gain, most negative bias input
        configure(255, -128, 1'b0);
        send_sample(make_sample(127, 127, 127, 127, -128, 0));
        send_sample(make_sample(-128, -128, -128, -128, 127, 0));
        send_sample(make_sample(-128, 127, -128, 127, -1, 1));

        // zero bias input, an epoch with no error
        configure(1, 0, 1'b0);
        send_sample(make_sample(0, 0, 0, 0, 0, 0));
        send_sample(make_sample(0, 0, 0, 0, 5, 1));

        // random phases: repeated training sets with some noise and missing epoch marks
        for (int p = 0; p < PHASES; p++) begin
            quiet = (p == 2 || p == 5);
            case (p)
                0: configure(255, 127, 1'b0);
                1: configure(255, -128, 1'b0);
                2: configure(1, 1, 1'b0);
                3: configure($urandom_range(1, 255), $urandom_range(0, 255), 1'b0);
                4: configure(0, $urandom_range(0, 255), 1'b0);
                5: configure(1, -128, 1'b0);
                6: configure($urandom_range(1, 255), 0, 1'b1);
                default: configure($urandom_range(1, 255), $urandom_range(0, 255), 1'b0);
            endcase
            bias = $signed(sb.bias_in);
            foreach (teacher[i]) teacher[i] = int'($urandom_range(0, 16)) - 8;
            train_set.delete();
            n = $urandom_range(2, 10);
            repeat (n) train_set.push_back(labelled_sample(bias));
            // one wrong label now and then, so the phase never settles
            if ($urandom_range(0, 3) == 0) train_set[0].tgt = ~train_set[0].tgt;

            sent = 0;
            while (sent < PHASE_WORDS) begin
                if ($urandom_range(0, 9) == 0) begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_sample(noise_sample());
                end else begin
                    n = train_set.size();
                    broken = ($urandom_range(0, 11) == 0);
                    foreach (train_set[i]) begin
                        s = train_set[i];
                        s.last = (i == n - 1) && !broken;
                        send_sample(s);
                    end
                end
                sent += n;
            end
        end

        // let the last results come back, then report the verdict
        i_in_valid <= 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("perceptron_weight_trainer_core verification clean");
        end else begin
            $display("perceptron_weight_trainer_core verification failed");
        end
        $finish;
    end

endmodule
